// File: rtl/assert_macros.svh
// Assertion macros used by the receive checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ICMP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ICMP_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ICMP_ASSERT(label, clk, rst_n, prop, msg)
`define ICMP_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// File: rtl/icmp_rc_pkg.sv
// Types, constants and helper functions for the ICMP receive checker.
package icmp_rc_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int PAYLOAD_W   = 16;
    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

    localparam int MIN_ERROR_LEN = 4;
    localparam int MIN_ECHO_LEN  = 8;

    localparam int POS_TYPE     = 0;
    localparam int POS_CODE     = 1;
    localparam int POS_ID_HI    = 4;
    localparam int POS_ID_LO    = 5;
    localparam int POS_SEQ_HI   = 6;
    localparam int POS_SEQ_LO   = 7;

    localparam logic [7:0] TYPE_ECHO_REPLY     = 8'd0;
    localparam logic [7:0] TYPE_DEST_UNREACH   = 8'd3;
    localparam logic [7:0] TYPE_SOURCE_QUENCH  = 8'd4;
    localparam logic [7:0] TYPE_REDIRECT       = 8'd5;
    localparam logic [7:0] TYPE_ECHO_REQUEST   = 8'd8;
    localparam logic [7:0] TYPE_TIME_EXCEEDED  = 8'd11;
    localparam logic [7:0] TYPE_PARAM_PROBLEM  = 8'd12;
    localparam logic [7:0] CODE_ZERO           = 8'd0;
    localparam logic [15:0] SUM_GOOD           = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_req;

    typedef struct packed {
        logic                 checksum_ok;
        logic                 too_short;
        logic                 error_valid;
        logic                 echo_valid;
        logic                 echo_is_request;
        logic [7:0]           msg_type;
        logic [7:0]           msg_code;
        logic [15:0]          echo_identifier;
        logic [15:0]          echo_sequence;
        logic [PAYLOAD_W-1:0] payload_bytes;
    } t_result;

    // Ones'-complement add with end-around carry.
    function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, word};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic logic type_is_error(input logic [7:0] t);
        logic r;
        case (t) inside
            TYPE_DEST_UNREACH, TYPE_SOURCE_QUENCH, TYPE_REDIRECT,
            TYPE_TIME_EXCEEDED, TYPE_PARAM_PROBLEM: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/icmp_receive_checker.sv
// ICMP receive checker: byte-wise checksum, header capture and message verdict.
// Accepts one message byte per cycle and returns one verdict request per message,
// registered at the same edge at which the final byte leaves the input register.
// Each byte passes an input register and then the checksum add, header capture
// and verdict logic into the result register, so the sustained rate is one byte
// per cycle; a final byte waits in the input register only while an earlier verdict
// is still held at the output.
`include "assert_macros.svh"

module icmp_receive_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  icmp_rc_pkg::t_in_req  i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output icmp_rc_pkg::t_result  o_out_result
);

    localparam int LB = icmp_rc_pkg::LENGTH_BITS;

    logic                 r_in_vld;
    icmp_rc_pkg::t_in_req r_in;
    logic                 r_out_vld;
    icmp_rc_pkg::t_result r_out;

    logic [15:0]   r_sum;
    logic [LB-1:0] r_count;
    logic [7:0]    r_held;
    logic          r_odd;
    logic [7:0]    r_type;
    logic [7:0]    r_code;
    logic [15:0]   r_ident;
    logic [15:0]   r_seq;

    logic [15:0]   n_sum;
    logic [LB-1:0] n_count;
    logic [7:0]    n_type;
    logic [7:0]    n_code;
    logic [15:0]   n_ident;
    logic [15:0]   n_seq;
    logic [15:0]   step_word;
    logic          advance;
    logic          finish;
    logic          chk_ok;
    logic          echo_ok;
    icmp_rc_pkg::t_result n_out;

    assign advance    = r_in_vld && (!r_in.last_byte || !r_out_vld || i_out_ready);
    assign finish     = advance && r_in.last_byte;
    assign o_in_ready = !r_in_vld || advance;

    always_comb begin
        n_type  = r_type;
        n_code  = r_code;
        n_ident = r_ident;
        n_seq   = r_seq;
        case (r_count)
            LB'(icmp_rc_pkg::POS_TYPE):   n_type         = r_in.data_byte;
            LB'(icmp_rc_pkg::POS_CODE):   n_code         = r_in.data_byte;
            LB'(icmp_rc_pkg::POS_ID_HI):  n_ident[15:8]  = r_in.data_byte;
            LB'(icmp_rc_pkg::POS_ID_LO):  n_ident[7:0]   = r_in.data_byte;
            LB'(icmp_rc_pkg::POS_SEQ_HI): n_seq[15:8]    = r_in.data_byte;
            LB'(icmp_rc_pkg::POS_SEQ_LO): n_seq[7:0]     = r_in.data_byte;
            default: ;
        endcase
    end

    // Pad an unpaired byte with a zero low byte; this also gives the final sum.
    assign step_word = r_odd ? {r_held, r_in.data_byte} : {r_in.data_byte, 8'h00};
    assign n_sum     = icmp_rc_pkg::ones_add(r_sum, step_word);
    assign n_count   = (r_count == icmp_rc_pkg::COUNT_MAX) ? r_count : r_count + 1'b1;

    assign chk_ok  = (n_sum == icmp_rc_pkg::SUM_GOOD);
    assign echo_ok = (n_count >= LB'(icmp_rc_pkg::MIN_ECHO_LEN)) && chk_ok
                     && (n_code == icmp_rc_pkg::CODE_ZERO)
                     && ((n_type == icmp_rc_pkg::TYPE_ECHO_REQUEST)
                         || (n_type == icmp_rc_pkg::TYPE_ECHO_REPLY));

    always_comb begin
        n_out.checksum_ok     = chk_ok;
        n_out.too_short       = (n_count < LB'(icmp_rc_pkg::MIN_ERROR_LEN));
        n_out.error_valid     = (n_count >= LB'(icmp_rc_pkg::MIN_ERROR_LEN)) && chk_ok
                                && icmp_rc_pkg::type_is_error(n_type);
        n_out.echo_valid      = echo_ok;
        n_out.echo_is_request = echo_ok && (n_type == icmp_rc_pkg::TYPE_ECHO_REQUEST);
        n_out.msg_type        = n_type;
        n_out.msg_code        = n_code;
        n_out.echo_identifier = n_ident;
        n_out.echo_sequence   = n_seq;
        n_out.payload_bytes   = echo_ok
            ? icmp_rc_pkg::PAYLOAD_W'(n_count - LB'(icmp_rc_pkg::MIN_ECHO_LEN))
            : '0;
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_req;
        end
    end

    // Message state: advance per byte, clear after the final byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || finish) begin
            r_sum   <= '0;
            r_count <= '0;
            r_held  <= '0;
            r_odd   <= 1'b0;
            r_type  <= '0;
            r_code  <= '0;
            r_ident <= '0;
            r_seq   <= '0;
        end else if (advance) begin
            if (r_odd) begin
                r_sum  <= n_sum;
                r_held <= '0;
            end else begin
                r_held <= r_in.data_byte;
            end
            r_odd   <= !r_odd;
            r_count <= n_count;
            r_type  <= n_type;
            r_code  <= n_code;
            r_ident <= n_ident;
            r_seq   <= n_seq;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (finish) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (finish) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_out_result = r_out;

    `ICMP_ASSERT(a_phase_tracks_count, i_clk, i_rst_n, (r_count != icmp_rc_pkg::COUNT_MAX) |-> (r_odd == r_count[0]), "odd phase out of step with byte count")
    `ICMP_ASSERT(a_clear_after_last, i_clk, i_rst_n, finish |=> (r_count == '0 && r_sum == '0 && !r_odd), "message state not cleared after final byte")
    `ICMP_ASSERT(a_result_from_last, i_clk, i_rst_n, $rose(r_out_vld) |-> $past(finish), "verdict raised without a final byte")
    `ICMP_ASSERT(a_no_overwrite, i_clk, i_rst_n, (r_out_vld && !i_out_ready) |-> !finish, "pending verdict overwritten")
    `ICMP_ASSERT(a_echo_needs_sum, i_clk, i_rst_n, (r_out_vld && r_out.echo_valid) |-> (r_out.checksum_ok && !r_out.too_short && !r_out.error_valid), "echo verdict inconsistent")

endmodule
